### design/tga_pkg.sv
`timescale 1ns / 1ps

package tga_pkg;

	// Result kinds
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_PIXELS = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// Error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_CMAP_TYPE = 3'd1;
	localparam logic [2:0] ERR_IMG_TYPE  = 3'd2;
	localparam logic [2:0] ERR_INTERLEAV = 3'd3;
	localparam logic [2:0] ERR_DEPTH     = 3'd4;

	// Header layout and image types
	localparam logic [4:0] HDR_LAST_POS       = 5'd17;
	localparam logic [7:0] TYPE_TRUECOLOR     = 8'd2;
	localparam logic [7:0] TYPE_RLE_TRUECOLOR = 8'd10;
	localparam logic [7:0] MAX_DESCRIPTOR     = 8'd32;

	// One input beat
	typedef struct packed {
		logic [7:0] data;
		logic       sof;
	} tga_in_t;

	// One result beat
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] pixel_value;
		logic [7:0]  repeat_count;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic        has_alpha;
		logic [2:0]  error_code;
		logic        last;
	} tga_res_t;

endpackage

### design/tga_in_stage.sv
`timescale 1ns / 1ps

module tga_in_stage import tga_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  tga_in_t in_beat,
	input  logic    advance,
	output logic    valid_s1,
	output tga_in_t beat_s1
);

	// Input register: refills in the same cycle it drains
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_s1 <= in_beat;
		end
	end

endmodule

### design/tga_parser.sv
`timescale 1ns / 1ps

module tga_parser import tga_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  tga_in_t  beat,
	output logic     res_valid,
	output tga_res_t res
);

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_IDSKIP = 3'd1;
	localparam logic [2:0] PH_PIXELS = 3'd2;
	localparam logic [2:0] PH_DONE   = 3'd3;
	localparam logic [2:0] PH_ERROR  = 3'd4;

	logic [2:0]  phase_q, phase_d;
	logic [4:0]  hpos_q, hpos_d;
	logic [7:0]  id_left_q, id_left_d;
	logic        rle_q, rle_d;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic [7:0]  depth_q, depth_d;
	logic        four_q, four_d;
	logic [1:0]  bip_q, bip_d;
	logic [31:0] asm_q, asm_d;
	logic [7:0]  pkt_left_q, pkt_left_d;
	logic        is_run_q, is_run_d;
	logic [31:0] pix_left_q, pix_left_d;
	logic [2:0]  perr_q, perr_d;
	logic [31:0] area_q;

	logic [7:0]  b;
	logic [2:0]  ph_eff;
	logic [4:0]  hpos_eff;
	logic [2:0]  perr_eff;
	logic [2:0]  err_fin;
	logic        depth_ok;
	logic [31:0] asm_new;
	logic [1:0]  bip_last;
	logic [7:0]  cnt_raw;
	logic [7:0]  cnt;
	logic [31:0] pix_rem;

	assign b = beat.data;

	// Start mark restarts the header parse on this very beat
	assign ph_eff   = beat.sof ? PH_HEADER : phase_q;
	assign hpos_eff = beat.sof ? 5'd0 : hpos_q;
	assign perr_eff = beat.sof ? ERR_NONE : perr_q;

	assign depth_ok = depth_q inside {8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd24, 8'd32};

	// Final header check, in priority order
	always_comb begin
		err_fin = perr_eff;
		if (err_fin == ERR_NONE && b > MAX_DESCRIPTOR) begin
			err_fin = ERR_INTERLEAV;
		end
		if (err_fin == ERR_NONE && !depth_ok) begin
			err_fin = ERR_DEPTH;
		end
	end

	// Pixel assembly and run clipping
	assign asm_new  = asm_q | ({24'h0, b} << {bip_q, 3'b000});
	assign bip_last = four_q ? 2'd3 : 2'd2;
	assign cnt_raw  = (rle_q && is_run_q) ? pkt_left_q : 8'd1;
	assign cnt      = (pix_left_q < {24'h0, cnt_raw}) ? pix_left_q[7:0] : cnt_raw;
	assign pix_rem  = pix_left_q - {24'h0, cnt};

	// Next state and result
	always_comb begin
		phase_d    = ph_eff;
		hpos_d     = hpos_eff;
		id_left_d  = id_left_q;
		rle_d      = rle_q;
		width_d    = width_q;
		height_d   = height_q;
		depth_d    = depth_q;
		four_d     = four_q;
		bip_d      = bip_q;
		asm_d      = asm_q;
		pkt_left_d = pkt_left_q;
		is_run_d   = is_run_q;
		pix_left_d = pix_left_q;
		perr_d     = perr_eff;
		res_valid  = 1'b0;
		res        = '0;
		case (ph_eff)
			PH_HEADER: begin
				case (hpos_eff)
					5'd0: id_left_d = b;
					5'd1: perr_d = (b > 8'd1) ? ERR_CMAP_TYPE : ERR_NONE;
					5'd2: begin
						if (perr_eff == ERR_NONE && b != TYPE_TRUECOLOR &&
							b != TYPE_RLE_TRUECOLOR) begin
							perr_d = ERR_IMG_TYPE;
						end
						rle_d = (b == TYPE_RLE_TRUECOLOR);
					end
					5'd12: width_d  = {8'h0, b};
					5'd13: width_d  = width_q | {b, 8'h0};
					5'd14: height_d = {8'h0, b};
					5'd15: height_d = height_q | {b, 8'h0};
					5'd16: depth_d  = b;
					default: ;
				endcase
				if (hpos_eff < HDR_LAST_POS) begin
					hpos_d = hpos_eff + 5'd1;
				end else begin
					res_valid = 1'b1;
					perr_d    = err_fin;
					if (err_fin != ERR_NONE) begin
						phase_d        = PH_ERROR;
						res.kind       = KIND_ERROR;
						res.error_code = err_fin;
					end else begin
						four_d     = (depth_q == 8'd32);
						pix_left_d = area_q;
						bip_d      = 2'd0;
						asm_d      = '0;
						pkt_left_d = 8'd0;
						is_run_d   = 1'b0;
						if (area_q == 32'd0) begin
							phase_d = PH_DONE;
						end else if (id_left_q != 8'd0) begin
							phase_d = PH_IDSKIP;
						end else begin
							phase_d = PH_PIXELS;
						end
						res.kind         = KIND_HEADER;
						res.image_width  = width_q;
						res.image_height = height_q;
						res.has_alpha    = (depth_q == 8'd32);
					end
				end
			end
			PH_IDSKIP: begin
				id_left_d = id_left_q - 8'd1;
				if (id_left_q == 8'd1) begin
					phase_d = PH_PIXELS;
				end
			end
			PH_PIXELS: begin
				if (rle_q && pkt_left_q == 8'd0) begin
					// packet header byte
					is_run_d   = b[7];
					pkt_left_d = {1'b0, b[6:0]} + 8'd1;
				end else if (bip_q != bip_last) begin
					bip_d = bip_q + 2'd1;
					asm_d = asm_new;
				end else begin
					bip_d = 2'd0;
					asm_d = '0;
					if (rle_q) begin
						pkt_left_d = is_run_q ? 8'd0 : pkt_left_q - 8'd1;
					end
					pix_left_d = pix_rem;
					if (pix_rem == 32'd0) begin
						phase_d = PH_DONE;
					end
					res_valid        = 1'b1;
					res.kind         = KIND_PIXELS;
					res.pixel_value  = asm_new;
					res.repeat_count = cnt;
					res.last         = (pix_rem == 32'd0);
				end
			end
			default: ;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			hpos_q     <= 5'd0;
			id_left_q  <= 8'd0;
			rle_q      <= 1'b0;
			width_q    <= 16'd0;
			height_q   <= 16'd0;
			depth_q    <= 8'd0;
			four_q     <= 1'b0;
			bip_q      <= 2'd0;
			asm_q      <= 32'd0;
			pkt_left_q <= 8'd0;
			is_run_q   <= 1'b0;
			pix_left_q <= 32'd0;
			perr_q     <= ERR_NONE;
		end else if (en) begin
			phase_q    <= phase_d;
			hpos_q     <= hpos_d;
			id_left_q  <= id_left_d;
			rle_q      <= rle_d;
			width_q    <= width_d;
			height_q   <= height_d;
			depth_q    <= depth_d;
			four_q     <= four_d;
			bip_q      <= bip_d;
			asm_q      <= asm_d;
			pkt_left_q <= pkt_left_d;
			is_run_q   <= is_run_d;
			pix_left_q <= pix_left_d;
			perr_q     <= perr_d;
		end
	end

	// Pixel count: width and height are final before the depth byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_q <= 32'd0;
		end else if (en && ph_eff == PH_HEADER && hpos_eff == 5'd16) begin
			area_q <= {16'h0, width_q} * {16'h0, height_q};
		end
	end

endmodule

### design/tga_out_reg.sv
`timescale 1ns / 1ps

module tga_out_reg import tga_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     load,
	input  tga_res_t res_in,
	input  logic     out_ready,
	output logic     out_valid,
	output logic     can_load,
	output tga_res_t res_q
);

	// Result register: free when empty or being taken this cycle
	assign can_load = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (can_load) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load) begin
			res_q <= res_in;
		end
	end

endmodule

### design/tga_truecolor_stream_decoder_top.sv
`timescale 1ns / 1ps

// Streaming decoder for truecolor TGA files (raw, type 2, or run-length coded,
// type 10). Feed the file one byte per beat; start_of_file marks header byte 0
// and abandons any file in progress. The 18-byte header yields one header
// beat (or one error beat), the ID field is skipped, and every pixel, literal
// or whole run comes out as one beat with a repeat count, clipped to
// width*height pixels; last flags the beat that completes the image. Bytes
// after the image or after an error are dropped until the next start mark.
// The block takes one byte per cycle while out_ready stays high; a byte is
// registered on entry, decoded combinationally against the parser state and
// lands in the result register. The width*height product is registered on
// the depth byte.

module tga_truecolor_stream_decoder_top import tga_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        start_of_file,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [31:0] pixel_value,
	output logic [7:0]  repeat_count,
	output logic [15:0] image_width,
	output logic [15:0] image_height,
	output logic        has_alpha,
	output logic [2:0]  error_code,
	output logic        last
);

	tga_in_t  in_beat;
	tga_in_t  beat_s1;
	logic     valid_s1;
	logic     advance;
	logic     can_load;
	logic     res_valid;
	tga_res_t res;
	tga_res_t res_q;

	assign in_beat.data = data_byte;
	assign in_beat.sof  = start_of_file;

	// A byte is decoded only when the result register has room
	assign advance = valid_s1 && can_load;

	tga_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_beat  (in_beat),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	tga_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.beat      (beat_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	tga_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_valid),
		.res_in    (res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.can_load  (can_load),
		.res_q     (res_q)
	);

	assign kind         = res_q.kind;
	assign pixel_value  = res_q.pixel_value;
	assign repeat_count = res_q.repeat_count;
	assign image_width  = res_q.image_width;
	assign image_height = res_q.image_height;
	assign has_alpha    = res_q.has_alpha;
	assign error_code   = res_q.error_code;
	assign last         = res_q.last;

endmodule

### design/tga_checker.sv
`timescale 1ns / 1ps

module tga_checker import tga_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [31:0] pixel_value,
	input logic [7:0]  repeat_count,
	input logic [2:0]  error_code,
	input logic        last
);

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) &&
		$stable(pixel_value) && $stable(repeat_count) && $stable(error_code))
		else $error("result beat changed while stalled");

	// Pixel beats always cover at least one pixel
	a_pix_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_PIXELS |-> repeat_count != 8'd0 &&
		error_code == ERR_NONE)
		else $error("pixel beat with zero count or error code");

	// Error beats carry a real code and no pixel data
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ERROR |-> error_code != ERR_NONE &&
		repeat_count == 8'd0 && !last)
		else $error("malformed error beat");

	// last only closes a pixel run
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> kind == KIND_PIXELS)
		else $error("last set on non-pixel beat");

endmodule

bind tga_truecolor_stream_decoder_top tga_checker u_tga_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.kind         (kind),
	.pixel_value  (pixel_value),
	.repeat_count (repeat_count),
	.error_code   (error_code),
	.last         (last)
);

### dv/tga_truecolor_stream_decoder_top_tb.sv
`timescale 1ns / 1ps

module tga_truecolor_stream_decoder_top_tb;
	import tga_pkg::*;

	// Header byte offsets that the decoder looks at
	localparam logic [4:0] HDR_ID_LEN   = 5'd0;
	localparam logic [4:0] HDR_CMAP     = 5'd1;
	localparam logic [4:0] HDR_IMG_TYPE = 5'd2;
	localparam logic [4:0] HDR_W_LO     = 5'd12;
	localparam logic [4:0] HDR_W_HI     = 5'd13;
	localparam logic [4:0] HDR_H_LO     = 5'd14;
	localparam logic [4:0] HDR_H_HI     = 5'd15;
	localparam logic [4:0] HDR_DEPTH    = 5'd16;
	localparam logic [7:0] DEPTH_BGRA   = 8'd32;
	localparam logic [7:0] DEPTH_BGR    = 8'd24;

	localparam int RANDOM_BYTES   = 450;
	localparam int QUIET_TAIL     = 120;
	localparam int DRAIN_CYCLES   = 12;
	localparam int WATCHDOG_LIMIT = 500;

	typedef enum logic [2:0] {
		ST_HEADER,
		ST_IDSKIP,
		ST_PIXELS,
		ST_DONE,
		ST_ERROR
	} parse_st_e;

	// DUT ports
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'd0;
	logic        start_of_file = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [31:0] pixel_value;
	logic [7:0]  repeat_count;
	logic [15:0] image_width;
	logic [15:0] image_height;
	logic        has_alpha;
	logic [2:0]  error_code;
	logic        last;

	tga_truecolor_stream_decoder_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.start_of_file(start_of_file),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.pixel_value  (pixel_value),
		.repeat_count (repeat_count),
		.image_width  (image_width),
		.image_height (image_height),
		.has_alpha    (has_alpha),
		.error_code   (error_code),
		.last         (last)
	);

	initial forever #6 clk = ~clk;

	// Stimulus and expectation stores
	tga_in_t  file_bytes[$];
	tga_res_t predicted_results[$];
	tga_in_t  next_byte;
	int       total_bytes;
	int       bytes_taken;
	int       src_idle;
	int       sink_stall;
	logic     tail_quiet = 1'b0;
	int       quiet_cycles;
	int       mismatches;
	int       files_sent;
	int       headers_seen;
	int       errors_seen;
	int       runs_seen;
	int       pixels_seen;
	int       images_done;
	int       bgra_headers;
	int       longest_run;

	// Decoder state mirrored by the predictor
	parse_st_e   st;
	logic [4:0]  hdr_pos;
	logic [7:0]  id_left;
	logic        rle;
	logic [15:0] w_st;
	logic [15:0] h_st;
	logic [7:0]  depth_st;
	logic        alpha_px;
	logic [1:0]  px_byte;
	logic [31:0] px_acc;
	logic [7:0]  pkt_left;
	logic        pkt_run;
	logic [31:0] px_left;
	logic [2:0]  err_pend;

	function automatic bit depth_ok(input logic [7:0] d);
		return d == 8'd1 || d == 8'd2 || d == 8'd4 || d == 8'd8 || d == 8'd16 ||
			d == DEPTH_BGR || d == DEPTH_BGRA;
	endfunction

	task automatic reset_decoder_model();
		st = ST_HEADER;
		hdr_pos = '0;
		id_left = '0;
		rle = 1'b0;
		w_st = '0;
		h_st = '0;
		depth_st = '0;
		alpha_px = 1'b0;
		px_byte = '0;
		px_acc = '0;
		pkt_left = '0;
		pkt_run = 1'b0;
		px_left = '0;
		err_pend = ERR_NONE;
	endtask

	// Predict the result (if any) of one accepted byte
	task automatic decode_byte(input logic [7:0] b, input logic sof);
		tga_res_t r;
		int       px_size;
		logic [7:0] cnt;
		r = '0;
		if (sof) begin
			st = ST_HEADER;
			hdr_pos = '0;
			err_pend = ERR_NONE;
		end
		case (st)
			ST_HEADER: begin
				case (hdr_pos)
					HDR_ID_LEN: id_left = b;
					HDR_CMAP: err_pend = (b > 8'd1) ? ERR_CMAP_TYPE : ERR_NONE;
					HDR_IMG_TYPE: begin
						if (err_pend == ERR_NONE && b != TYPE_TRUECOLOR &&
								b != TYPE_RLE_TRUECOLOR)
							err_pend = ERR_IMG_TYPE;
						rle = (b == TYPE_RLE_TRUECOLOR);
					end
					HDR_W_LO: w_st = {8'd0, b};
					HDR_W_HI: w_st[15:8] = b;
					HDR_H_LO: h_st = {8'd0, b};
					HDR_H_HI: h_st[15:8] = b;
					HDR_DEPTH: depth_st = b;
					default: ;
				endcase
				if (hdr_pos != HDR_LAST_POS) begin
					hdr_pos = hdr_pos + 5'd1;
				end else begin
					// descriptor byte closes the header
					if (err_pend == ERR_NONE && b > MAX_DESCRIPTOR)
						err_pend = ERR_INTERLEAV;
					if (err_pend == ERR_NONE && !depth_ok(depth_st))
						err_pend = ERR_DEPTH;
					if (err_pend != ERR_NONE) begin
						st = ST_ERROR;
						r.kind = KIND_ERROR;
						r.error_code = err_pend;
					end else begin
						alpha_px = (depth_st == DEPTH_BGRA);
						px_left = 32'(w_st) * 32'(h_st);
						px_byte = '0;
						px_acc = '0;
						pkt_left = '0;
						pkt_run = 1'b0;
						if (px_left == 0)
							st = ST_DONE;
						else if (id_left != 0)
							st = ST_IDSKIP;
						else
							st = ST_PIXELS;
						r.kind = KIND_HEADER;
						r.image_width = w_st;
						r.image_height = h_st;
						r.has_alpha = alpha_px;
					end
					predicted_results.push_back(r);
				end
			end
			ST_IDSKIP: begin
				id_left = id_left - 8'd1;
				if (id_left == 0)
					st = ST_PIXELS;
			end
			ST_PIXELS: begin
				px_size = alpha_px ? 4 : 3;
				if (rle && pkt_left == 0) begin
					// packet header: bit 7 marks a run
					pkt_run = b[7];
					pkt_left = {1'b0, b[6:0]} + 8'd1;
				end else begin
					px_acc = px_acc | (32'(b) << (8 * px_byte));
					if (int'(px_byte) + 1 < px_size) begin
						px_byte = px_byte + 2'd1;
					end else begin
						r.kind = KIND_PIXELS;
						r.pixel_value = px_acc;
						px_byte = '0;
						px_acc = '0;
						cnt = 8'd1;
						if (rle) begin
							if (pkt_run) begin
								cnt = pkt_left;
								pkt_left = '0;
							end else begin
								pkt_left = pkt_left - 8'd1;
							end
						end
						// clip at the end of the image
						if (32'(cnt) > px_left)
							cnt = px_left[7:0];
						px_left = px_left - 32'(cnt);
						r.repeat_count = cnt;
						r.last = (px_left == 0);
						if (r.last)
							st = ST_DONE;
						predicted_results.push_back(r);
					end
				end
			end
			default: ;
		endcase
	endtask

	// Stimulus building
	task automatic add_beat(input logic [7:0] b, input logic sof);
		tga_in_t it;
		it.data = b;
		it.sof = sof;
		file_bytes.push_back(it);
		if (sof)
			files_sent++;
	endtask

	task automatic add_header(input logic sof, input logic [7:0] id_len,
			input logic [7:0] cmap, input logic [7:0] itype, input logic [15:0] w,
			input logic [15:0] h, input logic [7:0] depth, input logic [7:0] desc);
		add_beat(id_len, sof);
		add_beat(cmap, 1'b0);
		add_beat(itype, 1'b0);
		// colormap spec and origin: don't care
		repeat (9) add_beat(8'($urandom), 1'b0);
		add_beat(w[7:0], 1'b0);
		add_beat(w[15:8], 1'b0);
		add_beat(h[7:0], 1'b0);
		add_beat(h[15:8], 1'b0);
		add_beat(depth, 1'b0);
		add_beat(desc, 1'b0);
	endtask

	task automatic add_pixel(input int px_size, input logic [31:0] v);
		for (int i = 0; i < px_size; i++)
			add_beat(v[8*i +: 8], 1'b0);
	endtask

	task automatic add_noise(input int n);
		repeat (n) add_beat(8'($urandom), 1'b0);
	endtask

	// Pixel data for npix pixels; RLE packets may overshoot the image
	task automatic add_pixel_data(input bit rle_img, input int px_size, input int npix);
		int covered;
		int n;
		bit is_run;
		covered = 0;
		while (covered < npix) begin
			if (!rle_img) begin
				add_pixel(px_size, $urandom);
				covered++;
			end else begin
				is_run = ($urandom_range(0, 9) < 6);
				if (is_run)
					n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 128) :
						$urandom_range(1, 8);
				else
					n = $urandom_range(1, 6);
				add_beat({is_run, 7'(n - 1)}, 1'b0);
				if (is_run) begin
					add_pixel(px_size, $urandom);
				end else begin
					for (int i = 0; i < n; i++)
						add_pixel(px_size, $urandom);
				end
				covered += n;
			end
		end
	endtask

	task automatic add_random_file();
		int roll;
		int start;
		int cut;
		int id_len;
		int d;
		logic [7:0]  cmap;
		logic [7:0]  itype;
		logic [7:0]  depth;
		logic [7:0]  desc;
		logic [15:0] w;
		logic [15:0] h;
		logic [2:0]  bad;
		bit rle_img;
		roll = $urandom_range(0, 99);
		rle_img = $urandom_range(0, 1);
		cmap = 8'($urandom_range(0, 1));
		itype = rle_img ? TYPE_RLE_TRUECOLOR : TYPE_TRUECOLOR;
		desc = 8'($urandom_range(0, 32));
		d = $urandom_range(0, 9);
		case ($urandom_range(0, 4))
			0: depth = 8'd1;
			1: depth = 8'd2;
			2: depth = 8'd4;
			3: depth = 8'd8;
			default: depth = 8'd16;
		endcase
		if (d < 6)
			depth = DEPTH_BGR;
		else if (d < 8)
			depth = DEPTH_BGRA;
		id_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
		if (rle_img) begin
			w = 16'($urandom_range(1, 24));
			h = 16'($urandom_range(1, 6));
		end else begin
			w = 16'($urandom_range(1, 5));
			h = 16'($urandom_range(1, 3));
		end
		if ($urandom_range(0, 19) == 0)
			w = 16'd0;
		if ($urandom_range(0, 19) == 0)
			h = 16'd0;
		start = file_bytes.size();
		if (roll < 75) begin
			// well-formed file, sometimes cut short or followed by junk
			add_header(1'b1, 8'(id_len), cmap, itype, w, h, depth, desc);
			add_noise(id_len);
			add_pixel_data(rle_img, (depth == DEPTH_BGRA) ? 4 : 3, int'(w) * int'(h));
			if ($urandom_range(0, 5) == 0) begin
				cut = $urandom_range(1, file_bytes.size() - start - 1);
				repeat (cut) void'(file_bytes.pop_back());
			end
			if ($urandom_range(0, 4) == 0)
				add_noise($urandom_range(1, 4));
		end else if (roll < 92) begin
			// rejected header, one or two fields broken
			repeat ($urandom_range(1, 2)) begin
				bad = 3'($urandom_range(1, 4));
				case (bad)
					ERR_CMAP_TYPE: cmap = 8'($urandom_range(2, 255));
					ERR_IMG_TYPE: begin
						itype = 8'($urandom);
						while (itype == TYPE_TRUECOLOR || itype == TYPE_RLE_TRUECOLOR)
							itype = 8'($urandom);
					end
					ERR_INTERLEAV: desc = 8'($urandom_range(33, 255));
					default: begin
						depth = 8'($urandom);
						while (depth_ok(depth))
							depth = 8'($urandom);
					end
				endcase
			end
			add_header(1'b1, 8'(id_len), cmap, itype, w, h, depth, desc);
			add_noise($urandom_range(0, 3));
		end else begin
			add_noise($urandom_range(1, 5));
		end
	endtask

	task automatic build_directed();
		// bytes before any start mark parse as a header; single raw pixel
		add_header(1'b0, 8'd0, 8'd0, TYPE_TRUECOLOR, 16'd1, 16'd1, DEPTH_BGR, 8'd0);
		add_pixel(3, 32'h00FF_00FF);
		// BGRA raw with ID field, descriptor at its limit, trailing bytes
		add_header(1'b1, 8'd2, 8'd1, TYPE_TRUECOLOR, 16'd2, 16'd1, DEPTH_BGRA, 8'd32);
		add_noise(2);
		add_pixel(4, 32'hFFFF_FFFF);
		add_pixel(4, 32'h0000_0000);
		add_beat(8'hFF, 1'b0);
		add_beat(8'h00, 1'b0);
		// header rejections, all but the last with a lower-priority fault too
		add_header(1'b1, 8'd0, 8'hFF, 8'hFF, 16'd1, 16'd1, DEPTH_BGR, 8'd0);
		add_beat(8'h55, 1'b0);
		add_header(1'b1, 8'd0, 8'd0, 8'hFF, 16'd1, 16'd1, 8'hFF, 8'hFF);
		add_header(1'b1, 8'd0, 8'd0, TYPE_RLE_TRUECOLOR, 16'd1, 16'd1, 8'd0, 8'hFF);
		add_header(1'b1, 8'd0, 8'd0, TYPE_TRUECOLOR, 16'd1, 16'd1, 8'd0, 8'd0);
		add_beat(8'hAA, 1'b0);
		// empty image with an ID field: header only, rest ignored
		add_header(1'b1, 8'd3, 8'd0, TYPE_TRUECOLOR, 16'd0, 16'd5, 8'd1, 8'd0);
		add_noise(4);
		// one full-length run covers the whole 16x8 image
		add_header(1'b1, 8'd0, 8'd0, TYPE_RLE_TRUECOLOR, 16'd16, 16'd8, 8'd16, 8'd8);
		add_beat(8'hFF, 1'b0);
		add_pixel(3, 32'h0012_3456);
		add_noise(2);
		// literal then a run clipped to the last pixel
		add_header(1'b1, 8'd0, 8'd0, TYPE_RLE_TRUECOLOR, 16'd3, 16'd1, DEPTH_BGRA, 8'd0);
		add_beat(8'h01, 1'b0);
		add_pixel(4, 32'h8000_0001);
		add_pixel(4, 32'h7FFF_FFFE);
		add_beat(8'h85, 1'b0);
		add_pixel(4, 32'hDEAD_BEEF);
		add_noise(3);
		// long literal packet, only its first pixel fits
		add_header(1'b1, 8'd0, 8'd0, TYPE_RLE_TRUECOLOR, 16'd1, 16'd1, 8'd2, 8'd0);
		add_beat(8'h7F, 1'b0);
		add_pixel(3, 32'h00A5_5A0F);
		add_pixel(3, 32'h0001_0203);
		// new file while the ID field is being skipped
		add_header(1'b1, 8'hFF, 8'd0, TYPE_TRUECOLOR, 16'hFFFF, 16'hFFFF, DEPTH_BGR, 8'd0);
		add_noise(4);
		// largest image, abandoned mid-pixel
		add_header(1'b1, 8'd0, 8'd0, TYPE_TRUECOLOR, 16'hFFFF, 16'hFFFF, DEPTH_BGRA, 8'd0);
		add_pixel(4, 32'hFFFF_FFFF);
		add_pixel(4, 32'h0000_0000);
		add_noise(2);
	endtask

	// Input driver: pops the pending bytes, inserts idle bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= 8'd0;
			start_of_file <= 1'b0;
			tail_quiet <= 1'b0;
			src_idle = 0;
			reset_decoder_model();
		end else begin
			if (in_valid && in_ready) begin
				decode_byte(data_byte, start_of_file);
				bytes_taken++;
			end
			if (!in_valid || in_ready) begin
				if (src_idle > 0) begin
					src_idle--;
					in_valid <= 1'b0;
				end else if (!tail_quiet && $urandom_range(0, 7) == 0) begin
					src_idle = $urandom_range(0, 3);
					in_valid <= 1'b0;
				end else if (file_bytes.size() != 0) begin
					next_byte = file_bytes.pop_front();
					in_valid <= 1'b1;
					data_byte <= next_byte.data;
					start_of_file <= next_byte.sof;
				end else begin
					in_valid <= 1'b0;
				end
			end
			tail_quiet <= (file_bytes.size() < QUIET_TAIL);
		end
	end

	// Compare one result beat with the oldest prediction
	task automatic check_result();
		tga_res_t got;
		tga_res_t want;
		got.kind = kind;
		got.pixel_value = pixel_value;
		got.repeat_count = repeat_count;
		got.image_width = image_width;
		got.image_height = image_height;
		got.has_alpha = has_alpha;
		got.error_code = error_code;
		got.last = last;
		case (got.kind)
			KIND_HEADER: begin
				headers_seen++;
				if (got.has_alpha)
					bgra_headers++;
			end
			KIND_ERROR: errors_seen++;
			default: begin
				runs_seen++;
				pixels_seen += got.repeat_count;
				if (got.last)
					images_done++;
				if (got.repeat_count > longest_run)
					longest_run = got.repeat_count;
			end
		endcase
		if (predicted_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: unexpected beat", $realtime);
				$display("  got kind=%0d pix=%h cnt=%0d w=%0d h=%0d a=%0d err=%0d last=%0d",
					got.kind, got.pixel_value, got.repeat_count, got.image_width,
					got.image_height, got.has_alpha, got.error_code, got.last);
			end
		end else begin
			want = predicted_results.pop_front();
			if (got.kind !== want.kind || got.pixel_value !== want.pixel_value ||
					got.repeat_count !== want.repeat_count ||
					got.image_width !== want.image_width ||
					got.image_height !== want.image_height ||
					got.has_alpha !== want.has_alpha || got.error_code !== want.error_code ||
					got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: mismatch", $realtime);
					$display("  exp kind=%0d pix=%h cnt=%0d w=%0d h=%0d a=%0d err=%0d last=%0d",
						want.kind, want.pixel_value, want.repeat_count, want.image_width,
						want.image_height, want.has_alpha, want.error_code, want.last);
					$display("  got kind=%0d pix=%h cnt=%0d w=%0d h=%0d a=%0d err=%0d last=%0d",
						got.kind, got.pixel_value, got.repeat_count, got.image_width,
						got.image_height, got.has_alpha, got.error_code, got.last);
				end
			end
		end
	endtask

	// Output monitor with random backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			sink_stall = 0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (sink_stall > 0) begin
				sink_stall--;
				out_ready <= 1'b0;
			end else if (!tail_quiet && $urandom_range(0, 7) == 0) begin
				sink_stall = $urandom_range(0, 3);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: too long without any beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("%0t: no beat for %0d cycles, %0d results still pending",
					$realtime, WATCHDOG_LIMIT, predicted_results.size());
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Stimulus setup, reset and end of run
	initial begin
		int target;
		build_directed();
		target = file_bytes.size() + RANDOM_BYTES;
		while (file_bytes.size() < target)
			add_random_file();
		total_bytes = file_bytes.size();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (bytes_taken != total_bytes || predicted_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		mismatches += predicted_results.size();
		$display("Streamed %0d bytes in %0d marked files: %0d headers (%0d BGRA), %0d rejects",
			total_bytes, files_sent, headers_seen, bgra_headers, errors_seen);
		$display("Pixel beats %0d covering %0d pixels, longest run %0d, %0d images completed",
			runs_seen, pixels_seen, longest_run, images_done);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
